>>> design/spq_pkg.sv
// Shared types, sizes and codes for the stable priority queue.
`default_nettype none

package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int FILL_BITS    = $clog2(DEPTH + 1);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [PAYLOAD_BITS-1:0] tag_t;
    typedef logic [FILL_BITS-1:0]    fill_t;

    typedef struct packed {
        logic [3:0] prio;
        tag_t       tag;
    } entry_t;

    typedef struct packed {
        logic        command;
        logic [3:0]  priority_req;
        logic [15:0] payload;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_priority;
        logic [15:0] out_payload;
        logic [4:0]  count;
    } rsp_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ent;
    } cell_ctl_t;

    function automatic tag_t to_tag(input logic [15:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[PAYLOAD_BITS-1:0];
    endfunction

    function automatic logic [15:0] from_tag(input tag_t t);
        logic [63:0] w;
        w = 64'(t);
        return w[15:0];
    endfunction

    function automatic logic [4:0] count5(input fill_t f);
        logic [63:0] w;
        w = 64'(f);
        return w[4:0];
    endfunction

endpackage

`default_nettype wire

>>> design/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and trades with its neighbors.
`default_nettype none

module spq_cell (
    input  wire logic              clk,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire logic              occupied,
    input  wire spq_pkg::entry_t   left_ent,
    input  wire logic              left_go,
    input  wire spq_pkg::entry_t   right_ent,
    output spq_pkg::entry_t        ent,
    output logic                   go
);

    spq_pkg::entry_t ent_reg;
    spq_pkg::entry_t ent_next;

    // A cell gives way to a new entry unless it holds one of equal or higher priority.
    assign go  = !(occupied && (ent_reg.prio >= ctl.ent.prio));
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.deq)
        begin
            ent_next = right_ent;
        end
        else if (ctl.enq && go)
        begin
            ent_next = left_go ? left_ent : ctl.ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

>>> design/stable_priority_queue_top.sv
// Top level of the stable priority queue built as a chain of storage cells.
`default_nettype none

// A request is taken at a rising edge where start is high and busy is low.
// An enqueue request places its entry behind every held entry of equal or
// higher priority, so ties leave in arrival order; a dequeue request removes
// the front entry. Every request gives exactly one response, shown on rsp
// for one cycle with done high, in the cycle after the request is taken.
// The response carries the status, the removed entry on a successful
// dequeue and the number of entries held afterwards.
// The chain of cells compares and shifts all entries in parallel, so a new
// request may follow in every cycle and busy is never raised.
// Reset empties the queue and clears done; the cell contents are not reset.
// The receiver cannot stall, so a response must be captured while done is high.
module stable_priority_queue_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire spq_pkg::req_t req,
    output logic               done,
    output spq_pkg::rsp_t      rsp
);

    spq_pkg::fill_t fill_reg;
    spq_pkg::fill_t fill_next;
    logic           done_reg;
    logic           done_next;
    spq_pkg::rsp_t  rsp_reg;
    spq_pkg::rsp_t  rsp_next;

    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    cell_ent [spq_pkg::DEPTH];
    logic               cell_go  [spq_pkg::DEPTH];

    logic accept;
    logic full;
    logic empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (fill_reg == spq_pkg::fill_t'(spq_pkg::DEPTH));
    assign empty  = (fill_reg == '0);

    assign ctl.enq      = accept && (req.command == spq_pkg::CMD_ENQ) && !full;
    assign ctl.deq      = accept && (req.command == spq_pkg::CMD_DEQ) && !empty;
    assign ctl.ent.prio = req.priority_req;
    assign ctl.ent.tag  = spq_pkg::to_tag(req.payload);

    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t left_ent;
        spq_pkg::entry_t right_ent;
        logic            left_go;
        logic            occupied;

        assign occupied = (spq_pkg::fill_t'(i) < fill_reg);

        if (i == 0)
        begin : g_first
            assign left_ent = '0;
            assign left_go  = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_ent = cell_ent[i-1];
            assign left_go  = cell_go[i-1];
        end

        if (i == spq_pkg::DEPTH - 1)
        begin : g_last
            assign right_ent = '0;
        end
        else
        begin : g_inner_right
            assign right_ent = cell_ent[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occupied  (occupied),
            .left_ent  (left_ent),
            .left_go   (left_go),
            .right_ent (right_ent),
            .ent       (cell_ent[i]),
            .go        (cell_go[i])
        );
    end

    always_comb
    begin
        fill_next = fill_reg;
        done_next = accept;
        rsp_next  = rsp_reg;
        if (accept)
        begin
            rsp_next.status       = spq_pkg::ST_OK;
            rsp_next.out_priority = '0;
            rsp_next.out_payload  = '0;
            if (req.command == spq_pkg::CMD_ENQ)
            begin
                if (full)
                begin
                    rsp_next.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    fill_next = fill_reg + spq_pkg::fill_t'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    rsp_next.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    fill_next             = fill_reg - spq_pkg::fill_t'(1);
                    rsp_next.out_priority = cell_ent[0].prio;
                    rsp_next.out_payload  = spq_pkg::from_tag(cell_ent[0].tag);
                end
            end
            rsp_next.count = spq_pkg::count5(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

>>> design/spq_checker.sv
// Port-level checks on the stable priority queue, bound to its top level.
`default_nettype none

module spq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire spq_pkg::req_t req,
    input wire logic          done,
    input wire spq_pkg::rsp_t rsp
);

    // Every taken request is answered in the next cycle.
    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request not answered in the next cycle");

    // No response appears without a request in the cycle before.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("response without a request");

    // A dequeue on an empty queue reports an empty count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == spq_pkg::ST_EMPTY) |-> (rsp.count == 5'd0))
        else $error("empty status with nonzero count");

    // A dropped enqueue reports a full queue.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == spq_pkg::ST_FULL) |-> (rsp.count == 5'(spq_pkg::DEPTH)))
        else $error("full status with count below depth");

    // Only a successful dequeue returns an entry.
    a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != spq_pkg::ST_OK || $past(req.command) == spq_pkg::CMD_ENQ))
        |-> (rsp.out_priority == 4'd0 && rsp.out_payload == 16'd0))
        else $error("entry returned without a successful dequeue");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
